// ----- hw/rtl/triangular_window_profile_smoother_defines.svh -----
// Assertion macros for the triangular window profile smoother.
`ifndef TRIANGULAR_WINDOW_PROFILE_SMOOTHER_DEFINES_SVH
`define TRIANGULAR_WINDOW_PROFILE_SMOOTHER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define TWPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("twps: property failed");

// Check that a condition implies another in the same cycle.
`define TWPS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("twps: implication failed");

`else

`define TWPS_ASSERT(label, clk, rst_n, prop)
`define TWPS_ASSERT_IMPL(label, clk, rst_n, pre, post)

`endif

`endif

// ----- hw/rtl/twps_pkg.sv -----
// Shared types, constants and the reciprocal table of the profile smoother.
`default_nettype none

package twps_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int CFG_BITS    = 5;
    localparam int RECIP_FRAC  = 20;
    localparam int RECIP_BITS  = RECIP_FRAC + 1;
    // four channels of 24 bits fill whole bytes, so no padding
    localparam int TDATA_BITS  = CHANNELS * SAMPLE_BITS;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] t_sample;

    // round(2^20 / h^2) for h = 0..31; h = 0 never reaches the table
    localparam logic [RECIP_BITS-1:0] RECIP_LUT [2**CFG_BITS] = '{
        21'd1048576, 21'd1048576, 21'd262144, 21'd116508,
        21'd65536,   21'd41943,   21'd29127,  21'd21400,
        21'd16384,   21'd12945,   21'd10486,  21'd8666,
        21'd7282,    21'd6205,    21'd5350,   21'd4660,
        21'd4096,    21'd3628,    21'd3236,   21'd2905,
        21'd2621,    21'd2378,    21'd2166,   21'd1982,
        21'd1820,    21'd1678,    21'd1551,   21'd1438,
        21'd1337,    21'd1247,    21'd1165,   21'd1091
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TAPS,
        ST_DRAIN,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;   // take the input transaction
        logic start;  // clear accumulators, set first tap
        logic tap;    // issue one tap read
        logic scale;  // multiply sums by the reciprocal
        logic push;   // load the output register
        logic next;   // step to the next flushed position
    } t_cmd;

    typedef struct packed {
        logic has_emit;
        logic tap_last;
        logic out_free;
        logic more;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/triangular_window_profile_smoother.sv -----
// Top level of the triangular window profile smoother.
// Takes four-channel profile samples (signed Q8.16) and returns each profile
// position smoothed by a triangular window of half width h, taken from the
// half width register (0 acts as 1, values above MAX_HALF_WIDTH are clamped).
// Position p comes out when sample p+h arrives; the transaction with tlast set
// flushes all pending positions, the last of them with tlast set. Edges repeat
// the first and last sample. An input transaction is accepted in the idle state;
// each result it causes then takes start, tap, drain, scale and output steps
// (one tap per cycle through the single read port of the sample memory), and
// no new sample is taken until the last of those results is pushed. A
// finished result may wait in the output register while the next sample is
// taken. Write the half width only while no profile is in flight.
`default_nettype none
`include "triangular_window_profile_smoother_defines.svh"

module triangular_window_profile_smoother #(
    parameter int MAX_HALF_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // mean_velocity, stress_xx, stress_yy, stress_zz (24 bits each)
    input  wire logic [twps_pkg::TDATA_BITS-1:0] s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // smooth_velocity, smooth_xx, smooth_yy, smooth_zz (24 bits each)
    output logic [twps_pkg::TDATA_BITS-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [twps_pkg::CFG_BITS-1:0]   i_cfg_wr_data
);
    import twps_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_sample in_sample;
    t_sample out_sample;

    assign in_sample    = s_axis_tdata;
    assign m_axis_tdata = out_sample;

    twps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    twps_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (in_sample),
        .i_in_last     (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (out_sample),
        .o_out_last    (m_axis_tlast)
    );

    // never overwrite a result the sink has not taken
    `TWPS_ASSERT_IMPL(a_push_free, i_clk, i_rst_n, cmd.push, status.out_free)
    // no new transaction while a result is being computed
    `TWPS_ASSERT(a_ready_quiet, i_clk, i_rst_n, !(s_axis_tready && (cmd.tap || cmd.scale || cmd.push)))
    // output valid rises only from a push
    `TWPS_ASSERT_IMPL(a_valid_src, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(cmd.push))

endmodule

`default_nettype wire

// ----- hw/rtl/twps_ctrl.sv -----
// Sequencer for the profile smoother: accept, tap loop, scale, output.
`default_nettype none

module twps_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire twps_pkg::t_status i_status,
    output twps_pkg::t_cmd         o_cmd
);
    import twps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (!i_status.has_emit) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_TAPS;
                end
            end
            ST_TAPS: begin
                o_cmd.tap = 1'b1;
                if (i_status.tap_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // let the last tap reach the accumulators
            ST_DRAIN: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_status.more) begin
                        o_cmd.next = 1'b1;
                        n_state    = ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/twps_datapath.sv -----
// Sample memory, tap addressing, multiply-accumulate, scaling and output register.
`default_nettype none

module twps_datapath #(
    parameter int MAX_HALF_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire twps_pkg::t_cmd               i_cmd,
    output twps_pkg::t_status                 o_status,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [twps_pkg::CFG_BITS-1:0] i_cfg_wr_data,
    input  wire twps_pkg::t_sample            i_in_data,
    input  wire logic                         i_in_last,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output twps_pkg::t_sample                 o_out_data,
    output logic                              o_out_last
);
    import twps_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int AB    = $clog2(DEPTH);
    localparam int FB    = $clog2(DEPTH + 1);
    localparam int HB    = $clog2(MAX_HALF_WIDTH + 1);
    localparam int KB    = $clog2(2 * MAX_HALF_WIDTH) + 1;
    localparam int TB    = SAMPLE_BITS + HB + 1;
    localparam int AW    = SAMPLE_BITS + 2 * HB;
    localparam int PW    = AW + RECIP_BITS + 1;
    localparam logic signed [PW-1:0] SAT_MAX  = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PW-1:0] SAT_MIN  = -SAT_MAX - PW'(1);
    localparam logic signed [PW-1:0] RND_HALF = PW'(64'sd1 <<< (RECIP_FRAC - 1));

    // configuration and ring control
    logic [CFG_BITS-1:0] r_cfg_h;
    logic [AB-1:0]       r_wp;
    logic [AB-1:0]       n_wp;
    logic [FB-1:0]       r_fill;
    logic [FB-1:0]       n_fill;

    // per-transaction context
    logic [FB-1:0]       r_n;
    logic [HB-1:0]       r_h;
    logic                r_last;
    logic                r_emit;
    logic [HB-1:0]       r_kp;
    logic [HB-1:0]       n_kp;
    logic signed [KB-1:0] r_k;
    t_sample             r_hold;

    t_sample             mem [DEPTH];
    t_sample             r_rd;
    logic                r_tap_v;
    logic [HB-1:0]       r_w;
    logic                r_sel_first;

    logic signed [AW-1:0] r_acc  [CHANNELS];
    logic signed [PW-1:0] r_prod [CHANNELS];

    logic                r_out_v;
    t_sample             r_out_data;
    logic                r_out_last;

    logic [HB-1:0]        h_eff;
    logic [KB-2:0]        kc;
    logic [AB:0]          ring_sum;
    logic [AB-1:0]        rd_addr;
    logic                 sel_first;
    logic signed [KB-1:0] kp_s;
    logic signed [KB-1:0] h_s;
    logic signed [KB-1:0] diff;
    logic [KB-1:0]        absd;
    logic [HB-1:0]        w;
    logic signed [KB-1:0] k_lo;
    logic signed [KB-1:0] k_init;
    t_sample              src;
    logic signed [TB-1:0] tap_prod [CHANNELS];
    logic signed [RECIP_BITS:0] recip_s;
    t_sample              y_sat;

    // clamp the half width to 1..MAX_HALF_WIDTH
    always_comb begin
        if (r_cfg_h == '0) begin
            h_eff = HB'(1);
        end else if (int'(r_cfg_h) > MAX_HALF_WIDTH) begin
            h_eff = HB'(MAX_HALF_WIDTH);
        end else begin
            h_eff = HB'(r_cfg_h);
        end
    end

    always_comb begin
        n_wp = (r_wp == AB'(DEPTH - 1)) ? '0 : r_wp + AB'(1);
        if (i_in_last) begin
            n_fill = '0;
        end else if (r_fill == FB'(DEPTH)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FB'(1);
        end
        // a short profile flushes from its oldest position
        if (i_in_last && (r_fill < h_eff)) begin
            n_kp = HB'(r_fill);
        end else begin
            n_kp = h_eff;
        end
    end

    // tap address: k places before the newest sample, clamped at the newest
    always_comb begin
        kp_s     = KB'($signed({1'b0, r_kp}));
        h_s      = KB'($signed({1'b0, r_h}));
        kc       = r_k[KB-1] ? '0 : r_k[KB-2:0];
        sel_first = (kc > r_n);
        ring_sum = (AB+1)'(r_wp) + (AB+1)'(DEPTH - 1) - (AB+1)'(kc);
        rd_addr  = (ring_sum >= (AB+1)'(DEPTH)) ? AB'(ring_sum - (AB+1)'(DEPTH))
                                                : AB'(ring_sum);
        diff     = r_k - kp_s;
        absd     = diff[KB-1] ? KB'(-diff) : KB'(diff);
        w        = r_h - HB'(absd);
        k_lo     = kp_s - h_s + KB'(1);
        k_init   = kp_s + h_s - KB'(1);
    end

    always_comb begin
        src     = r_sel_first ? r_hold : r_rd;
        recip_s = $signed({1'b0, RECIP_LUT[CFG_BITS'(r_h)]});
        for (int c = 0; c < CHANNELS; c++) begin
            tap_prod[c] = $signed(src[c]) * $signed({1'b0, r_w});
        end
    end

    // round half up, then saturate
    always_comb begin
        logic signed [PW-1:0] y;
        for (int c = 0; c < CHANNELS; c++) begin
            y = (r_prod[c] + RND_HALF) >>> RECIP_FRAC;
            if (y > SAT_MAX) begin
                y = SAT_MAX;
            end else if (y < SAT_MIN) begin
                y = SAT_MIN;
            end
            y_sat[c] = y[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_h <= CFG_BITS'(1);
            r_wp    <= '0;
            r_fill  <= '0;
            r_tap_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_h <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
            r_tap_v <= i_cmd.tap;
            if (i_cmd.push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= r_fill;
            r_h    <= h_eff;
            r_last <= i_in_last;
            r_emit <= i_in_last || (r_fill >= h_eff);
            r_kp   <= n_kp;
            if (r_fill == '0) begin
                r_hold <= i_in_data;
            end
        end else if (i_cmd.next) begin
            r_kp <= r_kp - HB'(1);
        end
        if (i_cmd.start) begin
            r_k <= k_init;
        end else if (i_cmd.tap) begin
            r_k <= r_k - KB'(1);
        end
        r_w         <= w;
        r_sel_first <= sel_first;
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_cmd.start) begin
                r_acc[c] <= '0;
            end else if (r_tap_v) begin
                r_acc[c] <= r_acc[c] + AW'(tap_prod[c]);
            end
            if (i_cmd.scale) begin
                r_prod[c] <= r_acc[c] * recip_s;
            end
        end
        if (i_cmd.push) begin
            r_out_data <= y_sat;
            r_out_last <= r_last && (r_kp == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[r_wp] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
    end

    assign o_status.has_emit = r_emit;
    assign o_status.tap_last = (r_k == k_lo);
    assign o_status.out_free = !r_out_v || i_out_ready;
    assign o_status.more     = r_last && (r_kp != '0);

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire
